[design/obw_pkg.sv]
// ----------------------------------------------------------------------------
// obw_pkg
// shared types, register codes and helpers of the oriented box bounds block
// ----------------------------------------------------------------------------
package obw_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SIZE_X   = 3'd0;
	localparam logic [2:0] REG_SIZE_Y   = 3'd1;
	localparam logic [2:0] REG_SIZE_Z   = 3'd2;
	localparam logic [2:0] REG_OFFSET_X = 3'd3;
	localparam logic [2:0] REG_OFFSET_Y = 3'd4;
	localparam logic [2:0] REG_OFFSET_Z = 3'd5;
	localparam logic [2:0] REG_PIVOT    = 3'd6;

	// register stages after the normalizers: product, term, center, bounds
	localparam int POST_STAGES = 4;

	// per-vector side info that rides along the root and divide pipelines
	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} norm_sb_t;

	// normalizer latency: abs, shift, square, sum, 32 root steps,
	// dividend, one step per quotient bit, clamp
	function automatic int norm_lat(input int frac_bits);
		norm_lat = frac_bits + 39;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

endpackage

[design/obw_sqrt.sv]
// ----------------------------------------------------------------------------
// obw_sqrt
// pipelined integer square root of a 64-bit value, one root bit per stage
// ----------------------------------------------------------------------------
module obw_sqrt #(
	parameter int SB_W = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [63:0]     in_rad,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [31:0]     out_root,
	output logic [SB_W-1:0] out_sb
);

	logic [63:0]     rem_s [1:32];
	logic [63:0]     rt_s  [1:32];
	logic [SB_W-1:0] sb_s  [1:32];
	logic [32:1]     vld_s;

	for (genvar i = 0; i < 32; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0]     rem_in;
		logic [63:0]     rt_in;
		logic [SB_W-1:0] sb_in;
		logic            vld_in;
		logic [63:0]     trial;
		logic            take;

		if (i == 0) begin : g_first
			assign rem_in = in_rad;
			assign rt_in  = '0;
			assign sb_in  = in_sb;
			assign vld_in = in_vld;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign rt_in  = rt_s[i];
			assign sb_in  = sb_s[i];
			assign vld_in = vld_s[i];
		end

		always_comb begin
			trial = rt_in + BIT;
			take  = rem_in >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? rem_in - trial : rem_in;
			rt_s[i+1]  <= take ? (rt_in >> 1) + BIT : rt_in >> 1;
			sb_s[i+1]  <= sb_in;
		end
	end

	assign out_vld  = vld_s[32];
	assign out_root = rt_s[32][31:0];
	assign out_sb   = sb_s[32];

endmodule

[design/obw_div.sv]
// ----------------------------------------------------------------------------
// obw_div
// pipelined restoring divider, three dividends over one shared divisor,
// one quotient bit per stage
// ----------------------------------------------------------------------------
module obw_div #(
	parameter  int QB   = 17,
	parameter  int SB_W = 4,
	localparam int NW   = QB + 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [NW-1:0]   in_num [3],
	input  logic [31:0]     in_den,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [QB-1:0]   out_quo [3],
	output logic [SB_W-1:0] out_sb
);

	logic [31:0]     rem_s [1:QB][3];
	logic [QB-1:0]   quo_s [1:QB][3];
	logic [NW-1:0]   num_s [1:QB][3];
	logic [31:0]     den_s [1:QB];
	logic [SB_W-1:0] sb_s  [1:QB];
	logic [QB:1]     vld_s;

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int BI = QB - 1 - j;
		logic [31:0]     rem_in [3];
		logic [QB-1:0]   quo_in [3];
		logic [NW-1:0]   num_in [3];
		logic [31:0]     den_in;
		logic [SB_W-1:0] sb_in;
		logic            vld_in;
		logic [32:0]     part   [3];
		logic [32:0]     diff   [3];
		logic [2:0]      ge;

		if (j == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_lane
				// the top bits already sit below the divisor
				assign rem_in[l] = in_num[l][NW-1:QB];
				assign quo_in[l] = '0;
				assign num_in[l] = in_num[l];
			end
			assign den_in = in_den;
			assign sb_in  = in_sb;
			assign vld_in = in_vld;
		end else begin : g_next
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_in[l] = rem_s[j][l];
				assign quo_in[l] = quo_s[j][l];
				assign num_in[l] = num_s[j][l];
			end
			assign den_in = den_s[j];
			assign sb_in  = sb_s[j];
			assign vld_in = vld_s[j];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				part[l] = {rem_in[l], num_in[l][BI]};
				diff[l] = part[l] - {1'b0, den_in};
				ge[l]   = part[l] >= {1'b0, den_in};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j+1] <= 1'b0;
			else
				vld_s[j+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[j+1][l] <= ge[l] ? diff[l][31:0] : part[l][31:0];
				quo_s[j+1][l] <= {quo_in[l][QB-2:0], ge[l]};
				num_s[j+1][l] <= num_in[l];
			end
			den_s[j+1] <= den_in;
			sb_s[j+1]  <= sb_in;
		end
	end

	assign out_vld = vld_s[QB];
	assign out_sb  = sb_s[QB];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_quo[l] = quo_s[QB][l];
	end

endmodule

[design/obw_norm.sv]
// ----------------------------------------------------------------------------
// obw_norm
// normalizes one direction vector to unit length in fixed point
// ----------------------------------------------------------------------------
module obw_norm
	import obw_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic signed [31:0]          in_vec  [3],
	output logic                        out_vld,
	output logic signed [FRAC_BITS+1:0] out_axis [3]
);

	localparam int QB = FRAC_BITS + 1;
	localparam int NW = QB + 32;
	localparam int SB_W = 96 + $bits(norm_sb_t);
	localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

	// stage 1: magnitudes
	logic [31:0] mag_s1 [3];
	logic [2:0]  neg_s1;
	logic        vld_s1;

	// stage 2: magnitudes shifted so the largest has bit 30 or 31 set
	logic [31:0] mn_s2 [3];
	norm_sb_t    sb_s2;
	logic        vld_s2;

	// stage 3: squares
	logic [31:0] mn_s3 [3];
	logic [63:0] sq_s3 [3];
	norm_sb_t    sb_s3;
	logic        vld_s3;

	// stage 4: sum of squares
	logic [31:0] mn_s4 [3];
	logic [63:0] sum_s4;
	norm_sb_t    sb_s4;
	logic        vld_s4;

	logic [31:0] big;
	logic [31:0] tmp;
	logic [4:0]  shv;

	always_comb begin
		big = mag_s1[0];
		if (mag_s1[1] > big)
			big = mag_s1[1];
		if (mag_s1[2] > big)
			big = mag_s1[2];
		tmp = big;
		shv = '0;
		if (tmp < (32'd1 << 15)) begin
			tmp = tmp << 16;
			shv = shv | 5'd16;
		end
		if (tmp < (32'd1 << 23)) begin
			tmp = tmp << 8;
			shv = shv | 5'd8;
		end
		if (tmp < (32'd1 << 27)) begin
			tmp = tmp << 4;
			shv = shv | 5'd4;
		end
		if (tmp < (32'd1 << 29)) begin
			tmp = tmp << 2;
			shv = shv | 5'd2;
		end
		if (tmp < (32'd1 << 30)) begin
			tmp = tmp << 1;
			shv = shv | 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= in_vec[i][31] ? 32'(-in_vec[i]) : 32'(in_vec[i]);
			neg_s1[i] <= in_vec[i][31];
			mn_s2[i]  <= mag_s1[i] << shv;
			mn_s3[i]  <= mn_s2[i];
			sq_s3[i]  <= mn_s2[i] * mn_s2[i];
			mn_s4[i]  <= mn_s3[i];
		end
		sb_s2.neg  <= neg_s1;
		sb_s2.zero <= big == '0;
		sb_s3      <= sb_s2;
		sum_s4     <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		sb_s4      <= sb_s3;
	end

	// vector length
	logic            rt_vld;
	logic [31:0]     rt_len;
	logic [SB_W-1:0] rt_sb;

	obw_sqrt #(
		.SB_W(SB_W)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.in_rad  (sum_s4),
		.in_sb   ({mn_s4[0], mn_s4[1], mn_s4[2], sb_s4}),
		.out_vld (rt_vld),
		.out_root(rt_len),
		.out_sb  (rt_sb)
	);

	// stage 5: rounded dividends
	logic [NW-1:0] num_s5 [3];
	logic [31:0]   den_s5;
	norm_sb_t      sb_s5;
	logic          vld_s5;
	logic [31:0]   rt_mn [3];

	assign rt_mn[0] = rt_sb[SB_W-1 -: 32];
	assign rt_mn[1] = rt_sb[SB_W-33 -: 32];
	assign rt_mn[2] = rt_sb[SB_W-65 -: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= rt_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			num_s5[i] <= {1'b0, rt_mn[i], {FRAC_BITS{1'b0}}}
				+ {{(NW-31){1'b0}}, rt_len[31:1]};
		den_s5 <= rt_len;
		sb_s5  <= rt_sb[$bits(norm_sb_t)-1:0];
	end

	logic            dv_vld;
	logic [QB-1:0]   dv_quo [3];
	norm_sb_t        dv_sb;

	obw_div #(
		.QB  (QB),
		.SB_W($bits(norm_sb_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s5),
		.in_num (num_s5),
		.in_den (den_s5),
		.in_sb  (sb_s5),
		.out_vld(dv_vld),
		.out_quo(dv_quo),
		.out_sb (dv_sb)
	);

	// final stage: clamp to one, restore the sign, zero vector gives zero
	logic                        vld_s6;
	logic signed [FRAC_BITS+1:0] axis_s6 [3];
	logic [QB-1:0]               qc [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			qc[i] = (dv_quo[i] > ONE) ? ONE : dv_quo[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_sb.zero)
				axis_s6[i] <= '0;
			else if (dv_sb.neg[i])
				axis_s6[i] <= -$signed({1'b0, qc[i]});
			else
				axis_s6[i] <= $signed({1'b0, qc[i]});
		end
	end

	assign out_vld = vld_s6;
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign out_axis[i] = axis_s6[i];
	end

endmodule

[design/obb_world_bounds.sv]
// ----------------------------------------------------------------------------
// obb_world_bounds
// world center and axis-aligned bounds of an oriented box from an object pose
// ----------------------------------------------------------------------------
// A pose is taken on every clock cycle in which start is high; busy stays low,
// so one pose per cycle is sustained. The result appears on the output ports
// for one cycle with done high, after the normalizers and the product, term,
// center and bounds registers; there is no back-pressure, the receiver must
// take it then. The normalizers hold a 32-step square root and a divider with
// one step per quotient bit (FRAC_BITS + 1 steps), both fully pipelined.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready,
// and should only change while no pose is in flight.
module obb_world_bounds
	import obw_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] right_x,
	input  logic signed [31:0] right_y,
	input  logic signed [31:0] right_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic signed [31:0] fwd_x,
	input  logic signed [31:0] fwd_y,
	input  logic signed [31:0] fwd_z,
	output logic               done,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic signed [31:0] center_z,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] min_z,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y,
	output logic signed [31:0] max_z
);

	localparam int NORM_LAT = norm_lat(FRAC_BITS);
	localparam int POS_LAT  = NORM_LAT + 2;
	localparam int AW       = FRAC_BITS + 2;
	localparam int PW       = FRAC_BITS + 31;

	// configuration
	logic [30:0]        size_q [3];
	logic signed [31:0] off_q  [3];
	logic               pivot_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				size_q[i] <= '0;
				off_q[i]  <= '0;
			end
			pivot_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIZE_X:   size_q[0] <= cfg_data[30:0];
				REG_SIZE_Y:   size_q[1] <= cfg_data[30:0];
				REG_SIZE_Z:   size_q[2] <= cfg_data[30:0];
				REG_OFFSET_X: off_q[0]  <= cfg_data;
				REG_OFFSET_Y: off_q[1]  <= cfg_data;
				REG_OFFSET_Z: off_q[2]  <= cfg_data;
				REG_PIVOT:    pivot_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic acc;
	assign acc = start && !busy;

	// normalizers, one per axis: right, up, forward
	logic signed [31:0]   vec  [3][3];
	logic                 nv   [3];
	logic signed [AW-1:0] axis [3][3];

	assign vec[0][0] = right_x;
	assign vec[0][1] = right_y;
	assign vec[0][2] = right_z;
	assign vec[1][0] = up_x;
	assign vec[1][1] = up_y;
	assign vec[1][2] = up_z;
	assign vec[2][0] = fwd_x;
	assign vec[2][1] = fwd_y;
	assign vec[2][2] = fwd_z;

	for (genvar a = 0; a < 3; a++) begin : g_norm
		obw_norm #(
			.FRAC_BITS(FRAC_BITS)
		) u_norm (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (acc),
			.in_vec  (vec[a]),
			.out_vld (nv[a]),
			.out_axis(axis[a])
		);
	end

	// position delay, lines up with the term stage
	logic signed [31:0] pos_dl [POS_LAT][3];

	always_ff @(posedge clk) begin
		pos_dl[0][0] <= pos_x;
		pos_dl[0][1] <= pos_y;
		pos_dl[0][2] <= pos_z;
		for (int k = 1; k < POS_LAT; k++)
			pos_dl[k] <= pos_dl[k-1];
	end

	// stage 1: |axis| * half extent
	logic [PW-1:0] prod_s1 [3][3];
	logic          neg_s1  [3][3];
	logic          vld_s1;
	logic [FRAC_BITS:0] amag [3][3];

	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int c = 0; c < 3; c++)
				amag[a][c] = axis[a][c][AW-1] ? (FRAC_BITS+1)'(-axis[a][c])
					: (FRAC_BITS+1)'(axis[a][c]);
	end

	// stage 2: rounded signed terms
	logic signed [31:0] term_s2 [3][3];
	logic               vld_s2;
	logic [PW-1:0]      rnd [3][3];

	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int c = 0; c < 3; c++)
				rnd[a][c] = (prod_s1[a][c] + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
	end

	// stage 3: saturated center and unsaturated spread
	logic signed [31:0] ctr_s3 [3];
	logic [32:0]        spr_s3 [3];
	logic               vld_s3;
	logic signed [33:0] tx  [3][3];
	logic signed [33:0] csum [3];
	logic [32:0]        ssum [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < 3; a++)
				tx[a][c] = {{2{term_s2[a][c][31]}}, term_s2[a][c]};
			csum[c] = {{2{pos_dl[POS_LAT-1][c][31]}}, pos_dl[POS_LAT-1][c]}
				+ {{2{off_q[c][31]}}, off_q[c]};
			if (pivot_q)
				csum[c] = csum[c] + tx[1][c];
			else
				csum[c] = csum[c] + tx[0][c] + tx[1][c] + tx[2][c];
			ssum[c] = '0;
			for (int a = 0; a < 3; a++)
				ssum[c] = ssum[c] + (tx[a][c][33] ? 33'(-tx[a][c]) : 33'(tx[a][c]));
		end
	end

	// stage 4: output registers
	logic signed [31:0] ctr_s4 [3];
	logic signed [31:0] lo_s4  [3];
	logic signed [31:0] hi_s4  [3];
	logic               vld_s4;
	logic signed [33:0] cx [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			cx[c] = {{2{ctr_s3[c][31]}}, ctr_s3[c]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= nv[0];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[a][c] <= PW'(amag[a][c]) * PW'(size_q[a][30:1]);
				neg_s1[a][c]  <= axis[a][c][AW-1];
				term_s2[a][c] <= neg_s1[a][c] ? -$signed({1'b0, rnd[a][c][30:0]})
					: $signed({1'b0, rnd[a][c][30:0]});
			end
		end
		for (int c = 0; c < 3; c++) begin
			ctr_s3[c] <= sat32(csum[c]);
			spr_s3[c] <= ssum[c];
			ctr_s4[c] <= ctr_s3[c];
			lo_s4[c]  <= sat32(cx[c] - $signed({1'b0, spr_s3[c]}));
			hi_s4[c]  <= sat32(cx[c] + $signed({1'b0, spr_s3[c]}));
		end
	end

	assign done     = vld_s4;
	assign center_x = ctr_s4[0];
	assign center_y = ctr_s4[1];
	assign center_z = ctr_s4[2];
	assign min_x    = lo_s4[0];
	assign min_y    = lo_s4[1];
	assign min_z    = lo_s4[2];
	assign max_x    = hi_s4[0];
	assign max_y    = hi_s4[1];
	assign max_z    = hi_s4[2];

endmodule

[design/obw_chk.sv]
// ----------------------------------------------------------------------------
// obw_chk
// port-level checks of the oriented box bounds block
// ----------------------------------------------------------------------------
module obw_chk
	import obw_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] center_x,
	input logic signed [31:0] center_y,
	input logic signed [31:0] center_z,
	input logic signed [31:0] min_x,
	input logic signed [31:0] min_y,
	input logic signed [31:0] min_z,
	input logic signed [31:0] max_x,
	input logic signed [31:0] max_y,
	input logic signed [31:0] max_z
);

	localparam int LAT = norm_lat(FRAC_BITS) + POST_STAGES;

	// every result traces back to a transfer a fixed latency earlier
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transfer");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
		else $error("min above max");

	a_ctr: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_x <= center_x) && (center_x <= max_x)
			&& (min_y <= center_y) && (center_y <= max_y)
			&& (min_z <= center_z) && (center_z <= max_z))
		else $error("center outside bounds");

endmodule

bind obb_world_bounds obw_chk #(.FRAC_BITS(FRAC_BITS)) u_obw_chk (.*);
